>>> rtl/ptfs_pkg.sv
// Shared types, constants and lookup functions for the packed tag field store.
package ptfs_pkg;

  // Field widths fixed by the item format
  localparam int SLOT_W  = 15;
  localparam int TAG_W   = 32;
  localparam int WIDTH_W = 6;
  localparam int STAT_W  = 2;
  localparam int OFF_W   = 5;

  // Stream packing widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Default sizing
  localparam int TAG_WORDS_DEF    = 1024;
  localparam int MAX_TAG_BITS_DEF = 32;

  // Reciprocal divide: q = (slot * RECIP) >> RECIP_SHIFT, exact for 15-bit slots
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 22;
  localparam int PROD_W      = SLOT_W + RECIP_W;

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_WIDTH = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  // Result passed from the sequencer to the output register
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
  } res_t;

  // Tags per word for a tag width of 1..32
  function automatic logic [WIDTH_W-1:0] per_word_f(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] pw;
    case (w) inside
      6'd1:           pw = 6'd32;
      6'd2:           pw = 6'd16;
      6'd3:           pw = 6'd10;
      6'd4:           pw = 6'd8;
      6'd5:           pw = 6'd6;
      6'd6:           pw = 6'd5;
      [6'd7:6'd8]:    pw = 6'd4;
      [6'd9:6'd10]:   pw = 6'd3;
      [6'd11:6'd16]:  pw = 6'd2;
      default:        pw = 6'd1;
    endcase
    return pw;
  endfunction

  // ceil(2^RECIP_SHIFT / tags per word) for a tag width of 1..32
  function automatic logic [RECIP_W-1:0] recip_f(input logic [WIDTH_W-1:0] w);
    logic [RECIP_W-1:0] r;
    case (w) inside
      6'd1:           r = 22'd65536;
      6'd2:           r = 22'd131072;
      6'd3:           r = 22'd209716;
      6'd4:           r = 22'd262144;
      6'd5:           r = 22'd349526;
      6'd6:           r = 22'd419431;
      [6'd7:6'd8]:    r = 22'd524288;
      [6'd9:6'd10]:   r = 22'd699051;
      [6'd11:6'd16]:  r = 22'd1048576;
      default:        r = 22'd2097152;
    endcase
    return r;
  endfunction

  // Low-aligned mask of w ones, all ones at full width
  function automatic logic [TAG_W-1:0] mask_f(input logic [WIDTH_W-1:0] w);
    logic [TAG_W-1:0] m;
    if (w >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << w) - 32'd1;
    end
    return m;
  endfunction

endpackage

>>> rtl/ptfs_ram.sv
// Tag word memory: one write port, one read port with registered read data.
module ptfs_ram #(
  parameter int DEPTH  = ptfs_pkg::TAG_WORDS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [ptfs_pkg::TAG_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [ptfs_pkg::TAG_W-1:0] rdata
);

  logic [ptfs_pkg::TAG_W-1:0] mem_r [DEPTH];
  logic [ptfs_pkg::TAG_W-1:0] rdata_r;

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ptfs_ctrl.sv
// Request sequencer: clearing pass, slot-to-word mapping and read-modify-write of one word.
module ptfs_ctrl #(
  parameter int TAG_WORDS    = ptfs_pkg::TAG_WORDS_DEF,
  parameter int MAX_TAG_BITS = ptfs_pkg::MAX_TAG_BITS_DEF,
  parameter int ADDR_W       = (TAG_WORDS > 1) ? $clog2(TAG_WORDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req,
  input  logic [ptfs_pkg::SLOT_W-1:0]  in_slot,
  input  logic [ptfs_pkg::TAG_W-1:0]   in_tag,
  input  logic [ptfs_pkg::WIDTH_W-1:0] width,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output ptfs_pkg::res_t               res,
  // memory port
  output logic                         ram_we,
  output logic [ADDR_W-1:0]            ram_waddr,
  output logic [ptfs_pkg::TAG_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [ADDR_W-1:0]            ram_raddr,
  input  logic [ptfs_pkg::TAG_W-1:0]   ram_rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_RMW   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(TAG_WORDS - 1);
  localparam logic [16:0]       WORDS_LIM  = 17'(TAG_WORDS);
  localparam logic [ptfs_pkg::WIDTH_W-1:0] MAX_W = ptfs_pkg::WIDTH_W'(MAX_TAG_BITS);

  logic [2:0]                         state_r, state_nxt;
  logic [ADDR_W-1:0]                  clr_r, clr_nxt;
  logic                               req_r, req_nxt;
  logic [ptfs_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic [ptfs_pkg::TAG_W-1:0]         tag_r, tag_nxt;
  logic [ptfs_pkg::WIDTH_W-1:0]       w_r, w_nxt;
  logic [ptfs_pkg::SLOT_W-1:0]        q_r, q_nxt;
  logic [ptfs_pkg::OFF_W-1:0]         rem_r, rem_nxt;
  logic [ptfs_pkg::OFF_W-1:0]         off_r, off_nxt;
  ptfs_pkg::res_t                     res_r, res_nxt;

  logic [ptfs_pkg::PROD_W-1:0]        prod;
  logic [20:0]                        qpw;
  logic [10:0]                        offp;
  logic [ptfs_pkg::TAG_W-1:0]         mask;
  logic [ptfs_pkg::TAG_W-1:0]         fmask;
  logic [ptfs_pkg::TAG_W-1:0]         new_word;
  logic [ptfs_pkg::TAG_W-1:0]         cur_word;
  logic                               width_ok;

  // Datapath: reciprocal divide, remainder, bit offset and field merge
  assign width_ok = (width != '0) && (width <= MAX_W);
  assign prod     = ptfs_pkg::PROD_W'(slot_r) * ptfs_pkg::PROD_W'(ptfs_pkg::recip_f(w_r));
  assign qpw      = 21'(q_r) * 21'(ptfs_pkg::per_word_f(w_r));
  assign offp     = 11'(rem_r) * 11'(w_r);
  assign mask     = ptfs_pkg::mask_f(w_r);
  assign fmask    = mask << off_r;
  assign new_word = (ram_rdata & ~fmask) | ((tag_r & mask) << off_r);
  assign cur_word = (req_r == ptfs_pkg::REQ_WRITE) ? new_word : ram_rdata;

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    req_nxt   = req_r;
    slot_nxt  = slot_r;
    tag_nxt   = tag_r;
    w_nxt     = w_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(q_r);
    ram_wdata = new_word;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(q_r);
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt  = in_req;
          slot_nxt = in_slot;
          tag_nxt  = in_tag;
          w_nxt    = width;
          if (width_ok) begin
            state_nxt = S_DIV;
          end else begin
            res_nxt.tag    = '0;
            res_nxt.status = ptfs_pkg::ST_BAD_WIDTH;
            state_nxt      = S_OUT;
          end
        end
      end
      S_DIV: begin
        q_nxt     = prod[ptfs_pkg::RECIP_SHIFT +: ptfs_pkg::SLOT_W];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (17'(q_r) >= WORDS_LIM) begin
          res_nxt.tag    = '0;
          res_nxt.status = ptfs_pkg::ST_RANGE;
          state_nxt      = S_OUT;
        end else begin
          ram_re    = 1'b1;
          rem_nxt   = ptfs_pkg::OFF_W'(21'(slot_r) - qpw);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        off_nxt   = ptfs_pkg::OFF_W'(offp);
        state_nxt = S_RMW;
      end
      S_RMW: begin
        ram_we         = (req_r == ptfs_pkg::REQ_WRITE);
        res_nxt.tag    = (cur_word >> off_r) & mask;
        res_nxt.status = ptfs_pkg::ST_OK;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Request payload and intermediate values
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    slot_r <= slot_nxt;
    tag_r  <= tag_nxt;
    w_r    <= w_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    off_r  <= off_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> rtl/packed_tag_field_store.sv
// Top level of the packed tag field store: config register, sequencer, memory, output register.
//
// Keeps TAG_WORDS words of 32 bits holding tags of cfg_wdata bits packed from bit 0 up,
// floor(32/width) tags per word. After reset a clearing pass writes zeros to every word,
// during which no item is accepted; the width register can be written at any time.
// Items are taken one at a time: a request with a valid width passes through the
// reciprocal multiply, the range check with the memory read, the offset multiply, the
// write-back of the word and the hand-off to the output register; a slot beyond the
// store stops after the range check and an invalid width goes straight to the hand-off.
// The next item is accepted in the cycle after the hand-off.
// The output register lets the next item be accepted while the previous result still
// waits on out_tready. Result status is 0 ok, 1 width invalid, 2 slot beyond the store;
// on an error tag_out is 0.
module packed_tag_field_store #(
  parameter int TAG_WORDS    = ptfs_pkg::TAG_WORDS_DEF,
  parameter int MAX_TAG_BITS = ptfs_pkg::MAX_TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [ptfs_pkg::WIDTH_W-1:0]    cfg_wdata,    // tag_width
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ptfs_pkg::IN_DATA_W-1:0]  in_tdata,     // slot_index[14:0], tag_value[46:15]
  input  logic                            in_tuser,     // req_type[0]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptfs_pkg::OUT_DATA_W-1:0] out_tdata,    // tag_out[31:0]
  output logic [ptfs_pkg::STAT_W-1:0]     out_tuser     // status[1:0]
);

  localparam int ADDR_W = (TAG_WORDS > 1) ? $clog2(TAG_WORDS) : 1;

  logic [ptfs_pkg::WIDTH_W-1:0] tag_width_r;
  logic                         out_valid_r;
  ptfs_pkg::res_t               out_res_r;

  logic                         res_valid;
  logic                         res_ready;
  ptfs_pkg::res_t               res;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [ptfs_pkg::TAG_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [ptfs_pkg::TAG_W-1:0]   ram_rdata;

  // Hold the tag width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_width_r <= '0;
    end else if (cfg_we) begin
      tag_width_r <= cfg_wdata;
    end
  end

  ptfs_ctrl #(
    .TAG_WORDS    (TAG_WORDS),
    .MAX_TAG_BITS (MAX_TAG_BITS),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_slot   (in_tdata[ptfs_pkg::SLOT_W-1:0]),
    .in_tag    (in_tdata[ptfs_pkg::SLOT_W +: ptfs_pkg::TAG_W]),
    .width     (tag_width_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ptfs_ram #(
    .DEPTH  (TAG_WORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load the output register when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.tag;
  assign out_tuser  = out_res_r.status;

endmodule

>>> rtl/ptfs_checker.sv
// Port-level checks for the packed tag field store, bound to the top level.
module ptfs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ptfs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [ptfs_pkg::STAT_W-1:0]     out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An error result carries a zero tag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ptfs_pkg::ST_OK) |-> out_tdata == '0)
    else $error("error result with nonzero tag");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ptfs_pkg::ST_OK) || (out_tuser == ptfs_pkg::ST_BAD_WIDTH)
                   || (out_tuser == ptfs_pkg::ST_RANGE))
    else $error("undefined status code");

  // One item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is at work");

endmodule

bind packed_tag_field_store ptfs_checker u_ptfs_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the packed tag field store, with its own tag store model.
module tb_top;
  import ptfs_pkg::*;

  localparam int STORE_WORDS = 1024;
  localparam int WIDTH_LIMIT = 32;
  localparam int SLOT_TOP    = 32767;
  localparam int PHASE_ITEMS = 50;
  localparam int RAND_PHASES = 15;
  localparam int CALM_PHASES = 2;
  localparam int SETTLE_CYC  = 12;

  typedef struct packed {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  value;
  } tag_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
  } tag_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [WIDTH_W-1:0]    cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  // Pending requests, expected results and the model of the tag store
  tag_req_t           pending_reqs[$];
  tag_result_t        expected_tags[$];
  logic [TAG_W-1:0]   model_words [STORE_WORDS];
  logic [WIDTH_W-1:0] model_width = '0;

  int   issued_cnt = 0;
  int   taken_cnt  = 0;
  int   fail_cnt   = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  logic in_took    = 1'b0;
  logic calm       = 1'b0;

  packed_tag_field_store uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one access and update the tag store model
  task automatic predict_tag_access(input tag_req_t rq, output tag_result_t res);
    int               per;
    int               word_ix;
    int               bit_off;
    logic [TAG_W-1:0] mask;
    res.tag    = '0;
    res.status = ST_OK;
    if (model_width == '0 || int'(model_width) > WIDTH_LIMIT) begin
      res.status = ST_BAD_WIDTH;
    end else begin
      per     = 32 / int'(model_width);
      word_ix = int'(rq.slot) / per;
      bit_off = (int'(rq.slot) % per) * int'(model_width);
      if (word_ix >= STORE_WORDS) begin
        res.status = ST_RANGE;
      end else begin
        mask = (int'(model_width) == 32) ? '1 : ((32'd1 << model_width) - 32'd1);
        if (rq.req == REQ_WRITE) begin
          model_words[word_ix] = (model_words[word_ix] & ~(mask << bit_off)) |
                                 ((rq.value & mask) << bit_off);
        end
        res.tag = (model_words[word_ix] >> bit_off) & mask;
      end
    end
  endtask

  task automatic queue_req(input logic req, input int slot, input logic [TAG_W-1:0] value);
    tag_req_t rq;
    rq.req   = req;
    rq.slot  = slot[SLOT_W-1:0];
    rq.value = value;
    pending_reqs.push_back(rq);
  endtask

  // Write the width register; only called while nothing is in flight
  task automatic set_tag_width(input int w);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= w[WIDTH_W-1:0];
    model_width = w[WIDTH_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every request is taken and every result has come back
  task automatic drain_results();
    while (!(pending_reqs.size() == 0 && taken_cnt == issued_cnt &&
             expected_tags.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Fill one phase: mostly write/read traffic on a few neighboring slots
  task automatic queue_random_phase(input int n);
    int               per;
    int               top_slot;
    int               base0;
    int               base1;
    int               s;
    int               pick;
    int               hot [8];
    logic             req;
    logic [TAG_W-1:0] value;
    if (model_width == '0 || int'(model_width) > WIDTH_LIMIT) begin
      top_slot = SLOT_TOP;
    end else begin
      per      = 32 / int'(model_width);
      top_slot = STORE_WORDS * per - 1;
      if (top_slot > SLOT_TOP) top_slot = SLOT_TOP;
    end
    base0 = $urandom_range(0, top_slot);
    base1 = $urandom_range(0, top_slot);
    for (int i = 0; i < 8; i++) begin
      s = ((i < 4) ? base0 : base1) + (i % 4);
      hot[i] = (s > top_slot) ? top_slot : s;
    end
    repeat (n) begin
      req  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        s = hot[$urandom_range(0, 7)];
      end else if (pick < 85) begin
        s = $urandom_range(0, top_slot);
      end else if (pick < 95) begin
        s = (top_slot < SLOT_TOP) ? top_slot + $urandom_range(0, 1) : top_slot;
      end else begin
        s = $urandom_range(0, SLOT_TOP);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        value = '0;
      end else if (pick == 1) begin
        value = '1;
      end else begin
        value = $urandom;
      end
      queue_req(req, s, value);
    end
  endtask

  // Driver: present queued requests, with random gaps outside the calm part
  always @(negedge clk) begin
    tag_req_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold the current item until it is taken
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left  = gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        gap_left  = $urandom_range(0, 4);
      end else begin
        rq = pending_reqs.pop_front();
        in_tdata   <= {1'b0, rq.value, rq.slot};
        in_tuser   <= rq.req;
        in_tvalid  <= 1'b1;
        issued_cnt = issued_cnt + 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on each taken request, check each result against the oldest expectation
  always @(posedge clk) begin
    tag_req_t    rq;
    tag_result_t res;
    tag_result_t exp_res;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_tags.size() == 0) begin
          $error("result with no request outstanding: tag_out %h status %0d",
                 out_tdata, out_tuser);
          fail_cnt = fail_cnt + 1;
        end else begin
          exp_res = expected_tags.pop_front();
          if (out_tdata !== exp_res.tag) begin
            $error("tag_out mismatch: expected %h, actual %h", exp_res.tag, out_tdata);
            fail_cnt = fail_cnt + 1;
          end
          if (out_tuser !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_tuser);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rq.slot  = in_tdata[SLOT_W-1:0];
        rq.value = in_tdata[SLOT_W +: TAG_W];
        rq.req   = in_tuser;
        predict_tag_access(rq, res);
        expected_tags.push_back(res);
        taken_cnt = taken_cnt + 1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int w;
    foreach (model_words[i]) model_words[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Width still at its reset value: tags disabled
    queue_req(REQ_WRITE, 0, '1);
    queue_req(REQ_READ, SLOT_TOP, '0);
    drain_results();

    // Widths above the maximum
    set_tag_width(63);
    queue_req(REQ_READ, 5, '0);
    queue_req(REQ_WRITE, 5, 32'd1);
    drain_results();
    set_tag_width(33);
    queue_req(REQ_WRITE, 0, '1);
    drain_results();

    // Full-width tags, last word and slots beyond the store
    set_tag_width(32);
    queue_req(REQ_WRITE, 0, '1);
    queue_req(REQ_READ, 0, '0);
    queue_req(REQ_WRITE, 1023, 32'hA5A5_5A5A);
    queue_req(REQ_READ, 1023, '1);
    queue_req(REQ_WRITE, 1024, '1);
    queue_req(REQ_READ, SLOT_TOP, '0);
    drain_results();

    // One-bit tags: the whole slot range fits
    set_tag_width(1);
    queue_req(REQ_WRITE, SLOT_TOP, '1);
    queue_req(REQ_READ, SLOT_TOP, '0);
    queue_req(REQ_WRITE, SLOT_TOP - 1, 32'hFFFF_FFFE);
    queue_req(REQ_READ, 0, '0);
    drain_results();

    // Three-bit tags leave two unused bits per word
    set_tag_width(3);
    queue_req(REQ_WRITE, 9, 32'd7);
    queue_req(REQ_READ, 0, '0);
    queue_req(REQ_WRITE, 10239, 32'd5);
    queue_req(REQ_READ, 10240, '0);
    drain_results();

    set_tag_width(16);
    queue_req(REQ_WRITE, 2047, 32'h1234_FFFF);
    queue_req(REQ_WRITE, 2048, '1);
    queue_req(REQ_READ, 2046, '0);
    drain_results();

    // Random phases, each with its own width
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p >= RAND_PHASES - CALM_PHASES) calm = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
      end else begin
        w = $urandom_range(1, 32);
      end
      set_tag_width(w);
      queue_random_phase(PHASE_ITEMS);
      drain_results();
    end

    if (fail_cnt == 0 && expected_tags.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
